// File: src/tcw_pkg.sv
// shared constants for the text console writer
// no dependencies; imported by the top level and its defaults
`timescale 1ns / 1ps

package tcw_pkg;

  // default screen geometry and tab stop
  localparam int ColsDefault     = 80;
  localparam int RowsDefault     = 25;
  localparam int TabWidthDefault = 4;

  // one screen cell: attribute in the upper byte, character in the lower
  localparam int CellW = 16;

  // configuration port
  localparam int          PaddrW      = 3;
  localparam logic [0:0]  RegTextAttr = 1'b0;
  localparam logic [7:0]  AttrReset   = 8'h0F;

  // command codes
  localparam logic [1:0] CmdPut       = 2'd0;
  localparam logic [1:0] CmdSetCursor = 2'd1;
  localparam logic [1:0] CmdReadCell  = 2'd2;
  localparam logic [1:0] CmdNop       = 2'd3;

  // control characters
  localparam logic [7:0] ChBackspace = 8'h08;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChSpace     = 8'h20;

endpackage

// File: src/tcw_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/text_console_writer.sv
// text console writer top level: command sequencer, cursor and config register
// depends on tcw_pkg and tcw_ram
`timescale 1ns / 1ps

// Text-mode console holding ROWS x COLS cells of {attribute, character}.
// Input channel (in_valid_i / in_ready_o) carries one command beat: put a
// character, set the cursor, read a cell, or no operation. Output channel
// (out_valid_o / out_ready_i) returns one beat per command with the cursor
// position afterwards, the cell bytes for a read and a scroll flag.
// The block works on one command at a time through a small sequencer around a
// single cell ram port pair; in_ready_o is high only while the sequencer idles.
// A put of a printable writes one cell, a tab writes TAB_WIDTH spaces, and a
// read cell or backspace first reads the cell ram. Every scroll copies rows
// up through the ram, one cell a cycle, then blanks the last row.
// The result sits in an output register, so a new command is taken while the
// previous beat still waits; if the receiver stalls, a finished command holds
// in the finish state until the output register frees up.
// After reset the cell ram is cleared, one cell a cycle, with in_ready_o
// low; config writes are taken throughout. text_attribute resets to 0x0F
// and the cursor to the top left cell.

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLS      = ColsDefault,
  parameter int ROWS      = RowsDefault,
  parameter int TAB_WIDTH = TabWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic [7:0]        char_code_i,
  input  logic [4:0]        row_i,
  input  logic [6:0]        col_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [4:0]        cursor_row_o,
  output logic [6:0]        cursor_col_o,
  output logic [7:0]        read_char_o,
  output logic [7:0]        read_attr_o,
  output logic              scrolled_o,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CELLS = ROWS * COLS;
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int AW    = $clog2(CELLS);
  localparam int TW    = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

  localparam logic [RW-1:0] LastRow   = RW'(ROWS - 1);
  localparam logic [CW-1:0] LastCol   = CW'(COLS - 1);
  localparam logic [AW-1:0] CopyLast  = AW'(CELLS - COLS);
  localparam logic [AW-1:0] BlankLast = AW'(CELLS - 1);

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StPut,
    StBsRd,
    StBsWr,
    StRead,
    StReadData,
    StCopy,
    StBlank,
    StFinish
  } state_e;

  state_e          state_q;
  logic [AW-1:0]   cnt_q;
  logic [RW-1:0]   cur_row_q;
  logic [CW-1:0]   cur_col_q;
  logic [RW-1:0]   pos_row_q;
  logic [CW-1:0]   pos_col_q;
  logic [7:0]      ch_q;
  logic [TW-1:0]   tab_left_q;
  logic            scrolled_q;
  logic [7:0]      rd_char_q;
  logic [7:0]      rd_attr_q;
  logic [7:0]      attr_q;

  logic            out_valid_q;
  logic [4:0]      out_row_q;
  logic [6:0]      out_col_q;
  logic [7:0]      out_char_q;
  logic [7:0]      out_attr_q;
  logic            out_scrolled_q;

  // clamped request position
  logic [RW-1:0]   in_row;
  logic [CW-1:0]   in_col;

  // cell address of the cursor, or of the read position while reading
  logic [RW-1:0]   sel_row;
  logic [CW-1:0]   sel_col;
  logic [AW-1:0]   cell_addr;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [CellW-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [CellW-1:0] ram_rdata;

  logic            cfg_write;
  logic            at_origin;
  logic            at_end;

  // out-of-range positions saturate to the last row or column
  always_comb begin
    in_row = (int'(row_i) >= ROWS) ? LastRow : RW'(row_i);
    in_col = (int'(col_i) >= COLS) ? LastCol : CW'(col_i);
  end

  always_comb begin
    sel_row   = (state_q == StRead) ? pos_row_q : cur_row_q;
    sel_col   = (state_q == StRead) ? pos_col_q : cur_col_q;
    cell_addr = AW'(sel_row) * AW'(COLS) + AW'(sel_col);
  end

  assign at_origin = (cur_row_q == '0) && (cur_col_q == '0);
  // writing the last cell pushes the cursor off the screen
  assign at_end    = (cur_row_q == LastRow) && (cur_col_q == LastCol);

  // ram port steering per sequencer step
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr;
    ram_wdata = {attr_q, ch_q};
    ram_raddr = cell_addr;
    case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = '0;
      end
      StPut: begin
        ram_we = 1'b1;
      end
      StBsWr: begin
        // keep the attribute, blank the character
        ram_we    = 1'b1;
        ram_wdata = {ram_rdata[CellW-1:8], ChSpace};
      end
      StCopy: begin
        // read one row ahead, write the cell read in the previous cycle
        ram_we    = (cnt_q != '0);
        ram_waddr = cnt_q - AW'(1);
        ram_wdata = ram_rdata;
        if (cnt_q != CopyLast) begin
          ram_raddr = cnt_q + AW'(COLS);
        end
      end
      StBlank: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = {attr_q, ChSpace};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tcw_ram #(
    .Width (CellW),
    .Depth (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      cnt_q       <= '0;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      tab_left_q  <= '0;
      scrolled_q  <= 1'b0;
      attr_q      <= AttrReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_write && (paddr[2] == RegTextAttr)) begin
        attr_q <= pwdata[7:0];
      end

      // the finish state reloads the output register itself
      if (out_valid_q && out_ready_i && (state_q != StFinish)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StClear: begin
          if (cnt_q == BlankLast) begin
            cnt_q   <= '0;
            state_q <= StIdle;
          end else begin
            cnt_q <= cnt_q + AW'(1);
          end
        end

        StIdle: begin
          // scrolled_q and tab_left_q are already clear here
          if (in_valid_i) begin
            rd_char_q  <= '0;
            rd_attr_q  <= '0;
            ch_q       <= (char_code_i == ChTab) ? ChSpace : char_code_i;
            case (cmd_i)
              CmdPut: begin
                case (char_code_i)
                  ChNewline: begin
                    cur_col_q <= '0;
                    if (cur_row_q == LastRow) begin
                      scrolled_q <= 1'b1;
                      cnt_q      <= '0;
                      state_q    <= StCopy;
                    end else begin
                      cur_row_q <= cur_row_q + RW'(1);
                      state_q   <= StFinish;
                    end
                  end
                  ChBackspace: begin
                    if (at_origin) begin
                      state_q <= StFinish;
                    end else begin
                      if (cur_col_q == '0) begin
                        cur_col_q <= LastCol;
                        cur_row_q <= cur_row_q - RW'(1);
                      end else begin
                        cur_col_q <= cur_col_q - CW'(1);
                      end
                      state_q <= StBsRd;
                    end
                  end
                  ChTab: begin
                    tab_left_q <= TW'(TAB_WIDTH - 1);
                    state_q    <= StPut;
                  end
                  default: begin
                    state_q <= StPut;
                  end
                endcase
              end
              CmdSetCursor: begin
                cur_row_q <= in_row;
                cur_col_q <= in_col;
                state_q   <= StFinish;
              end
              CmdReadCell: begin
                pos_row_q <= in_row;
                pos_col_q <= in_col;
                state_q   <= StRead;
              end
              default: begin
                state_q <= StFinish;
              end
            endcase
          end
        end

        StPut: begin
          // cell written by the ram port this cycle, now advance
          if (cur_col_q == LastCol) begin
            cur_col_q <= '0;
            if (cur_row_q != LastRow) begin
              cur_row_q <= cur_row_q + RW'(1);
            end
          end else begin
            cur_col_q <= cur_col_q + CW'(1);
          end
          if (at_end) begin
            scrolled_q <= 1'b1;
            cnt_q      <= '0;
            state_q    <= StCopy;
          end else if (tab_left_q != '0) begin
            tab_left_q <= tab_left_q - TW'(1);
          end else begin
            state_q <= StFinish;
          end
        end

        StBsRd: begin
          state_q <= StBsWr;
        end

        StBsWr: begin
          state_q <= StFinish;
        end

        StRead: begin
          state_q <= StReadData;
        end

        StReadData: begin
          rd_char_q <= ram_rdata[7:0];
          rd_attr_q <= ram_rdata[CellW-1:8];
          state_q   <= StFinish;
        end

        StCopy: begin
          // cnt_q stays at the first cell of the last row for the blank pass
          if (cnt_q == CopyLast) begin
            state_q <= StBlank;
          end else begin
            cnt_q <= cnt_q + AW'(1);
          end
        end

        StBlank: begin
          if (cnt_q == BlankLast) begin
            cnt_q <= '0;
            if (tab_left_q != '0) begin
              tab_left_q <= tab_left_q - TW'(1);
              state_q    <= StPut;
            end else begin
              state_q <= StFinish;
            end
          end else begin
            cnt_q <= cnt_q + AW'(1);
          end
        end

        StFinish: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q    <= 1'b1;
            out_row_q      <= 5'(cur_row_q);
            out_col_q      <= 7'(cur_col_q);
            out_char_q     <= rd_char_q;
            out_attr_q     <= rd_attr_q;
            out_scrolled_q <= scrolled_q;
            scrolled_q     <= 1'b0;
            state_q        <= StIdle;
          end
        end

        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_ready_o   = (state_q == StIdle);
  assign out_valid_o  = out_valid_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign read_char_o  = out_char_q;
  assign read_attr_o  = out_attr_q;
  assign scrolled_o   = out_scrolled_q;

  // only the attribute register is mapped (paddr[2] clear); addresses with paddr[2] set read as zero
  assign prdata = (paddr[2] == RegTextAttr) ? {24'd0, attr_q} : 32'd0;
  assign pready = 1'b1;

endmodule

// File: tb/text_console_writer_tb.sv
// self-checking testbench for the text console writer
// drives command beats and apb attribute writes, predicts every status beat
// depends on tcw_pkg and the text_console_writer rtl
`timescale 1ns / 1ps

module text_console_writer_tb;
  import tcw_pkg::*;

  // geometry matches the default parameters of the instance
  localparam int Cols      = ColsDefault;
  localparam int Rows      = RowsDefault;
  localparam int TabW      = TabWidthDefault;
  localparam int Cells     = Rows * Cols;
  localparam int ClkPeriod = 4;

  // slowest legal run: every beat scrolls (about one screen copy each),
  // plus the ram clear after reset and the idle and stall gaps, then margin
  localparam int unsigned CycleLimit = 12_000_000;
  // settle time after the last status beat, well above the non-scroll latency
  localparam int TailCycles = 32;

  localparam logic [PaddrW-1:0] AttrAddr = PaddrW'(4 * RegTextAttr);

  // one status beat as it leaves the block
  typedef struct packed {
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] rd_char;
    logic [7:0] rd_attr;
    logic       scrolled;
  } status_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        cmd_i;
  logic [7:0]        char_code_i;
  logic [4:0]        row_i;
  logic [6:0]        col_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [4:0]        cursor_row_o;
  logic [6:0]        cursor_col_o;
  logic [7:0]        read_char_o;
  logic [7:0]        read_attr_o;
  logic              scrolled_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  text_console_writer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .char_code_i  (char_code_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .read_char_o  (read_char_o),
    .read_attr_o  (read_attr_o),
    .scrolled_o   (scrolled_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // shadow console: screen, cursor and attribute as the block should hold them
  // ---------------------------------------------------------------------------
  logic [15:0]  screen_m [Cells];
  int unsigned  cursor_m;
  logic [7:0]   attr_m;
  bit           scrolled_m;

  // status beats still owed by the block, oldest first
  status_t      status_due [$];

  int unsigned  mismatches;
  int unsigned  cycle_count;

  // knobs shared by the sender, the receiver and the test tasks
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  hold_off_len;

  function automatic int unsigned saturate(int unsigned v, int unsigned lim);
    return (v >= lim) ? lim - 1 : v;
  endfunction

  // cursor ran off the end: move every row up, blank the last one
  function automatic void wrap_screen();
    int k;
    if (cursor_m >= Cells) begin
      for (k = 0; k < Cells - Cols; k++) screen_m[k] = screen_m[k + Cols];
      for (k = Cells - Cols; k < Cells; k++) screen_m[k] = {attr_m, ChSpace};
      scrolled_m = 1'b1;
      cursor_m -= Cols;
    end
  endfunction

  function automatic void store_char(logic [7:0] ch);
    screen_m[cursor_m] = {attr_m, ch};
    cursor_m++;
    wrap_screen();
  endfunction

  // applies one accepted command to the shadow console, returns its status beat
  function automatic status_t apply_command(logic [1:0] cmd, logic [7:0] ch,
                                            logic [4:0] row, logic [6:0] col);
    status_t     s;
    int unsigned idx;
    s = '0;
    scrolled_m = 1'b0;
    case (cmd)
      CmdPut: begin
        if (ch == ChNewline) begin
          cursor_m = (cursor_m / Cols + 1) * Cols;
          wrap_screen();
        end else if (ch == ChBackspace) begin
          // blank the previous cell but keep its attribute; nothing at the origin
          if (cursor_m > 0) begin
            cursor_m--;
            screen_m[cursor_m][7:0] = ChSpace;
          end
        end else if (ch == ChTab) begin
          repeat (TabW) store_char(ChSpace);
        end else begin
          store_char(ch);
        end
      end
      CmdSetCursor: begin
        cursor_m = saturate(row, Rows) * Cols + saturate(col, Cols);
      end
      CmdReadCell: begin
        idx = saturate(row, Rows) * Cols + saturate(col, Cols);
        s.rd_char = screen_m[idx][7:0];
        s.rd_attr = screen_m[idx][15:8];
      end
      default: begin
        // no operation: only the cursor is reported
      end
    endcase
    s.row      = 5'(cursor_m / Cols);
    s.col      = 7'(cursor_m % Cols);
    s.scrolled = scrolled_m;
    return s;
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want,
                                        logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0s: expected 0x%0h, got 0x%0h (cycle %0d)",
               what, want, got, cycle_count);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls, plus one long hold-off when a test asks for it
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_len != 0) begin
        // keep ready low for the whole stretch, counted here in cycles
        n = hold_off_len;
        hold_off_len = 0;
        out_ready_i <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // every status beat is checked against the oldest prediction
  always @(posedge clk_i) begin
    status_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (status_due.size() == 0) begin
        note_mismatch("unexpected status beat", 32'h0,
                      32'({cursor_row_o, cursor_col_o, read_char_o, read_attr_o}));
      end else begin
        want = status_due.pop_front();
        if (cursor_row_o !== want.row)
          note_mismatch("cursor_row", 32'(want.row), 32'(cursor_row_o));
        if (cursor_col_o !== want.col)
          note_mismatch("cursor_col", 32'(want.col), 32'(cursor_col_o));
        if (read_char_o !== want.rd_char)
          note_mismatch("read_char", 32'(want.rd_char), 32'(read_char_o));
        if (read_attr_o !== want.rd_attr)
          note_mismatch("read_attr", 32'(want.rd_attr), 32'(read_attr_o));
        if (scrolled_o !== want.scrolled)
          note_mismatch("scrolled", 32'(want.scrolled), 32'(scrolled_o));
      end
    end
  end

  // hard stop if the run hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("text_console_writer_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------

  // offers one command beat after a random idle gap and waits for acceptance
  task automatic send_cmd(logic [1:0] cmd, logic [7:0] ch, logic [4:0] row,
                          logic [6:0] col);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    char_code_i <= ch;
    row_i       <= row;
    col_i       <= col;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    // beat taken at this edge: predict its status now
    status_due.push_back(apply_command(cmd, ch, row, col));
  endtask

  // drop valid and wait until every owed status beat has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
  endtask

  // one apb transfer: setup cycle, then access cycle until pready
  task automatic apb_cycle(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AttrAddr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write text_attribute (upper bits of the word are junk) and read it back
  task automatic program_attribute(logic [7:0] value);
    logic [31:0] rd;
    apb_cycle(1'b1, {24'($urandom_range(32'hFF_FFFF)), value}, rd);
    attr_m = value;
    apb_cycle(1'b0, $urandom, rd);
    if (rd !== {24'h0, attr_m})
      note_mismatch("text_attribute readback", {24'h0, attr_m}, rd);
  endtask

  // random command with realistic content; leans toward the last row so that
  // scrolls happen, and reads mostly look where text was just written
  task automatic random_command(output logic [1:0] cmd, output logic [7:0] ch,
                                output logic [4:0] row, output logic [6:0] col);
    int unsigned pick;
    int unsigned sub;
    int unsigned cur_row;
    pick    = $urandom_range(99);
    sub     = $urandom_range(9);
    cur_row = cursor_m / Cols;
    cmd     = CmdPut;
    ch      = 8'($urandom_range(255));
    row     = 5'($urandom_range(31));
    col     = 7'($urandom_range(127));
    if (pick < 45) begin
      cmd = CmdPut;
    end else if (pick < 53) begin
      ch = ChNewline;
    end else if (pick < 60) begin
      ch = ChBackspace;
    end else if (pick < 66) begin
      ch = ChTab;
    end else if (pick < 78) begin
      cmd = CmdSetCursor;
      if (sub < 4) begin
        row = 5'(Rows - 1);
        col = 7'($urandom_range(Cols - 1));
      end else if (sub < 6) begin
        row = 5'($urandom_range(Rows - 1));
        col = 7'($urandom_range(Cols - 1));
      end else if (sub < 8) begin
        row = 5'($urandom_range(Rows - 1));
        col = 7'($urandom_range(Cols - 1, Cols - 6));
      end
      // otherwise fully random, out-of-range rows and columns included
    end else if (pick < 95) begin
      cmd = CmdReadCell;
      if (sub < 5) begin
        row = 5'(cur_row);
        col = 7'($urandom_range(Cols - 1));
      end else if (sub < 7) begin
        row = 5'((cur_row == 0) ? Rows - 1 : cur_row - 1);
        col = 7'($urandom_range(Cols - 1));
      end
    end else begin
      cmd = CmdNop;
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // cleared cells, printable extremes and each control character
  task automatic test_control_chars();
    send_cmd(CmdReadCell, 8'hFF, 5'd0, 7'd0);
    send_cmd(CmdPut, 8'h41, 5'd31, 7'd127);
    send_cmd(CmdPut, 8'h00, 5'd0, 7'd0);
    send_cmd(CmdPut, 8'hFF, 5'd0, 7'd0);
    send_cmd(CmdPut, ChBackspace, 5'd0, 7'd0);
    send_cmd(CmdReadCell, 8'h00, 5'd0, 7'd2);
    send_cmd(CmdPut, ChTab, 5'd0, 7'd0);
    send_cmd(CmdPut, ChNewline, 5'd0, 7'd0);
    send_cmd(CmdSetCursor, 8'h00, 5'd0, 7'd0);
    // backspace at the origin does nothing
    send_cmd(CmdPut, ChBackspace, 5'd0, 7'd0);
    send_cmd(CmdNop, 8'hFF, 5'd31, 7'd127);
  endtask

  // saturating positions and scrolls by printable, newline and tab
  task automatic test_cursor_and_scroll();
    send_cmd(CmdSetCursor, 8'h00, 5'd31, 7'd127);
    send_cmd(CmdReadCell, 8'h00, 5'd31, 7'd127);
    send_cmd(CmdPut, 8'h5A, 5'd0, 7'd0);
    send_cmd(CmdReadCell, 8'h00, 5'd23, 7'd79);
    send_cmd(CmdReadCell, 8'h00, 5'd24, 7'd5);
    send_cmd(CmdSetCursor, 8'h00, 5'd24, 7'd79);
    send_cmd(CmdPut, ChNewline, 5'd0, 7'd0);
    // tab that crosses the end of the screen before its last space
    send_cmd(CmdSetCursor, 8'h00, 5'd24, 7'd77);
    send_cmd(CmdPut, ChTab, 5'd0, 7'd0);
    send_cmd(CmdReadCell, 8'h00, 5'd24, 7'd1);
    send_cmd(CmdSetCursor, 8'h00, 5'd25, 7'd3);
    send_cmd(CmdSetCursor, 8'h00, 5'd3, 7'd80);
    // backspace from column 0 steps back into the previous row
    send_cmd(CmdSetCursor, 8'h00, 5'd3, 7'd0);
    send_cmd(CmdPut, ChBackspace, 5'd0, 7'd0);
  endtask

  // one random phase at a given attribute and idling mix
  task automatic test_random_traffic(logic [7:0] attr, int unsigned idle_pct,
                                     int unsigned stall_pct, int unsigned n);
    logic [1:0] cmd;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;
    wait_drained();
    program_attribute(attr);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) begin
      random_command(cmd, ch, row, col);
      send_cmd(cmd, ch, row, col);
    end
  endtask

  // long receiver hold-off while commands keep coming, so the input stalls
  task automatic test_output_backpressure();
    logic [1:0] cmd;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_len   = 400;
    repeat (60) begin
      random_command(cmd, ch, row, col);
      send_cmd(cmd, ch, row, col);
    end
  endtask

  initial begin
    int k;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    cmd_i          = CmdNop;
    char_code_i    = 8'h00;
    row_i          = 5'd0;
    col_i          = 7'd0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = 32'h0;
    mismatches     = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_len   = 0;
    for (k = 0; k < Cells; k++) screen_m[k] = 16'h0000;
    cursor_m = 0;
    attr_m   = AttrReset;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed beats run at the reset attribute with mild idling
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    test_control_chars();
    test_cursor_and_scroll();

    test_random_traffic(8'hFF, 0, 0, 330);
    test_random_traffic(8'h00, 59, 0, 330);
    test_random_traffic(8'($urandom_range(255)), 0, 59, 330);
    test_output_backpressure();
    test_random_traffic(AttrReset, 16, 16, 330);

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("text_console_writer_tb OK");
    end else begin
      $display("text_console_writer_tb NOT OK");
    end
    $finish;
  end

endmodule
